[design/arm_pkg.sv]
// shared types, codes and sizes for the at response matcher
package arm_pkg;

    localparam int MAX_PATTERN  = 8;
    localparam int BUFFER_BYTES = 1024;
    localparam int WINDOW_BYTES = 8;
    localparam int COUNT_W      = 10;
    localparam int TICK_W       = 16;
    localparam int LEN_W        = 4;
    localparam int PATTERN_W    = 64;
    localparam int STATUS_W     = 3;
    localparam int CFG_INDEX_W  = 3;
    localparam int S_TDATA_W    = 8;
    localparam int M_TDATA_W    = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [TICK_W-1:0]  TICK_MAX  = '1;
    localparam int LIMIT_CAP_INT =
        ((BUFFER_BYTES - 1) < 1023) ? (BUFFER_BYTES - 1) : 1023;
    localparam logic [COUNT_W-1:0] LIMIT_CAP = COUNT_W'(LIMIT_CAP_INT);
    localparam int LEN_CAP_INT =
        (MAX_PATTERN < WINDOW_BYTES) ? MAX_PATTERN : WINDOW_BYTES;
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LEN_CAP_INT);

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_WAIT    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EXPECT  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FAIL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECT_PATTERN = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECT_LENGTH  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAIL_PATTERN   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAIL_LENGTH    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_TICKS  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_BUFFER_LIMIT   = 3'd5;

    // byte and fill flag handed from one cell to the next
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
    } arm_link_t;

    // per cell compare result on the window as it will be after this cycle
    typedef struct packed {
        logic filled;
        logic expect_eq;
        logic fail_eq;
    } arm_cell_stat_t;

    function automatic logic [LEN_W-1:0] arm_eff_len(input logic [LEN_W-1:0] len);
        arm_eff_len = (len > LEN_CAP) ? LEN_CAP : len;
    endfunction

endpackage

[design/arm_cell.sv]
// one byte position of the receive window with its pattern compares
module arm_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                shift_en,
    input  logic                clear,
    input  arm_pkg::arm_link_t  link_in,
    input  logic [7:0]          expect_byte,
    input  logic [7:0]          fail_byte,
    output arm_pkg::arm_link_t  link_out,
    output arm_pkg::arm_cell_stat_t stat
);
    import arm_pkg::*;

    logic [7:0] data_reg;
    logic [7:0] data_next;
    logic       valid_reg;
    logic       valid_next;

    always_comb begin
        data_next  = shift_en ? link_in.data : data_reg;
        valid_next = valid_reg;
        if (clear) begin
            valid_next = 1'b0;
        end else if (shift_en) begin
            valid_next = link_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign link_out.data   = data_reg;
    assign link_out.valid  = valid_reg;
    assign stat.filled     = valid_next;
    assign stat.expect_eq  = (data_next == expect_byte);
    assign stat.fail_eq    = (data_next == fail_byte);

endmodule

[design/at_response_matcher.sv]
// top level of the at response matcher: config registers, cell chain, counters, output word
// Takes one word per clock while s_tready is high: a start, a received byte or a tick each
// give one result word, loaded into the output register at the edge that accepts
// the input, so a result is offered in the cycle after its word is taken. The
// received byte shifts through a chain of eight byte cells that compare their
// contents against both patterns in the same cycle, so a match decision is
// registered at the edge that accepts its byte. The input stays ready while the output word
// waits, as long as the output register is being emptied in the same cycle.
// Registers are written through the cfg port, which is always ready.
module at_response_matcher (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [arm_pkg::S_TDATA_W-1:0]       s_tdata,   // rx_byte[7:0]
    input  logic [1:0]                          s_tuser,   // op[1:0]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [arm_pkg::M_TDATA_W-1:0]       m_tdata,   // status[2:0], received_count[12:3], zero pad
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [arm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [arm_pkg::PATTERN_W-1:0]       cfg_data
);
    import arm_pkg::*;

    logic [PATTERN_W-1:0] expect_pattern_reg;
    logic [LEN_W-1:0]     expect_length_reg;
    logic [PATTERN_W-1:0] fail_pattern_reg;
    logic [LEN_W-1:0]     fail_length_reg;
    logic [TICK_W-1:0]    timeout_ticks_reg;
    logic [COUNT_W-1:0]   buffer_limit_reg;

    logic [COUNT_W-1:0]   byte_total_reg;
    logic [COUNT_W-1:0]   byte_total_next;
    logic [COUNT_W-1:0]   byte_total_inc;
    logic [TICK_W-1:0]    elapsed_reg;
    logic [TICK_W-1:0]    elapsed_next;
    logic [STATUS_W-1:0]  status_reg;
    logic [STATUS_W-1:0]  status_next;

    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [COUNT_W-1:0]   out_count_reg;

    logic                 s_accept;
    logic                 do_start;
    logic                 do_byte;
    logic                 do_tick;
    logic [COUNT_W-1:0]   limit_eff;
    logic [LEN_W-1:0]     expect_len_eff;
    logic [LEN_W-1:0]     fail_len_eff;
    logic                 expect_hit;
    logic                 fail_hit;

    arm_link_t            links [WINDOW_BYTES+1];
    arm_cell_stat_t       stats [WINDOW_BYTES];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expect_pattern_reg <= '0;
            expect_length_reg  <= '0;
            fail_pattern_reg   <= '0;
            fail_length_reg    <= '0;
            timeout_ticks_reg  <= TICK_W'(5);
            buffer_limit_reg   <= COUNT_W'(1023);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_EXPECT_PATTERN: expect_pattern_reg <= cfg_data;
                CFG_EXPECT_LENGTH:  expect_length_reg  <= cfg_data[LEN_W-1:0];
                CFG_FAIL_PATTERN:   fail_pattern_reg   <= cfg_data;
                CFG_FAIL_LENGTH:    fail_length_reg    <= cfg_data[LEN_W-1:0];
                CFG_TIMEOUT_TICKS:  timeout_ticks_reg  <= cfg_data[TICK_W-1:0];
                CFG_BUFFER_LIMIT:   buffer_limit_reg   <= cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_tready = !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign do_start = s_accept && (s_tuser == OP_START);
    assign do_byte  = s_accept && (s_tuser == OP_BYTE) && (status_reg == ST_WAIT);
    assign do_tick  = s_accept && (s_tuser == OP_TICK) && (status_reg == ST_WAIT);

    // newest byte enters at cell zero
    assign links[0].data  = s_tdata[7:0];
    assign links[0].valid = 1'b1;

    for (genvar g = 0; g < WINDOW_BYTES; g++) begin : g_cell
        arm_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .shift_en    (do_byte),
            .clear       (do_start),
            .link_in     (links[g]),
            .expect_byte (expect_pattern_reg[8*g +: 8]),
            .fail_byte   (fail_pattern_reg[8*g +: 8]),
            .link_out    (links[g+1]),
            .stat        (stats[g])
        );
    end

    assign expect_len_eff = arm_eff_len(expect_length_reg);
    assign fail_len_eff   = arm_eff_len(fail_length_reg);

    always_comb begin
        expect_hit = (expect_len_eff != '0);
        fail_hit   = (fail_len_eff != '0);
        for (int i = 0; i < WINDOW_BYTES; i++) begin
            if (LEN_W'(i) < expect_len_eff) begin
                expect_hit = expect_hit && stats[i].filled && stats[i].expect_eq;
            end
            if (LEN_W'(i) < fail_len_eff) begin
                fail_hit = fail_hit && stats[i].filled && stats[i].fail_eq;
            end
        end
    end

    assign limit_eff      = (buffer_limit_reg > LIMIT_CAP) ? LIMIT_CAP : buffer_limit_reg;
    assign byte_total_inc = (byte_total_reg != COUNT_MAX) ? byte_total_reg + COUNT_W'(1)
                                                          : byte_total_reg;

    always_comb begin
        byte_total_next = byte_total_reg;
        elapsed_next    = elapsed_reg;
        status_next     = status_reg;
        if (do_start) begin
            byte_total_next = '0;
            elapsed_next    = '0;
            status_next     = ST_WAIT;
        end else if (do_byte) begin
            byte_total_next = byte_total_inc;
            if (fail_hit) begin
                status_next = ST_FAIL;
            end else if (expect_hit) begin
                status_next = ST_EXPECT;
            end else if (byte_total_inc >= limit_eff) begin
                status_next = ST_FULL;
            end
        end else if (do_tick) begin
            elapsed_next = (elapsed_reg != TICK_MAX) ? elapsed_reg + TICK_W'(1) : elapsed_reg;
            if (elapsed_next >= timeout_ticks_reg) begin
                status_next = ST_TIMEOUT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_total_reg <= '0;
            elapsed_reg    <= '0;
            status_reg     <= ST_WAIT;
            out_valid_reg  <= 1'b0;
        end else begin
            byte_total_reg <= byte_total_next;
            elapsed_reg    <= elapsed_next;
            status_reg     <= status_next;
            if (s_accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            out_status_reg <= status_next;
            out_count_reg  <= byte_total_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - STATUS_W - COUNT_W)'(0), out_count_reg, out_status_reg};

`ifndef SYNTHESIS
    a_start_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == OP_START)
        |=> (out_status_reg == ST_WAIT && out_count_reg == '0))
        else $error("start word did not produce a cleared result");

    a_ended_count_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (status_reg != ST_WAIT && !(s_tvalid && s_tready && s_tuser == OP_START))
        |=> $stable(byte_total_reg))
        else $error("byte count moved after the wait ended");

    a_window_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        links[1].valid == (byte_total_reg != '0))
        else $error("window fill flag out of step with byte count");
`endif

endmodule
